### hw/rtl/twdp_pkg.sv
`timescale 1ns / 1ps

package twdp_pkg;

   // Fixed result field widths
   localparam int LANE_IDX_W  = 4;
   localparam int COL_W       = 8;
   localparam int SUM_OUT_W   = 32;
   localparam int RSP_TDATA_W = 48;

   // Configuration port
   localparam int COUNT_W     = 9;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;

   // Register select, taken from paddr[2]
   localparam logic REG_COLUMN_COUNT = 1'b0;

   // Two-bit weight codes; the other two codes add nothing
   localparam logic [1:0] CODE_PLUS  = 2'd1;
   localparam logic [1:0] CODE_MINUS = 2'd2;

   // Handover from the lanes to the result drain
   typedef struct packed {
      logic             take;
      logic [COL_W-1:0] column;
   } capture_type;

endpackage

### hw/rtl/twdp_lane.sv
`timescale 1ns / 1ps

module twdp_lane #(
   parameter int ACT_WIDTH = 16,
   parameter int ACC_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic                        last,
   input  logic signed [ACT_WIDTH-1:0] activation,
   input  logic [1:0]                  code,
   output logic signed [ACC_WIDTH-1:0] sum_next,
   output logic                        sat_next
);

   localparam int SUM_W = ((ACC_WIDTH > ACT_WIDTH) ? ACC_WIDTH : ACT_WIDTH) + 1;

   localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
   localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

   logic signed [ACC_WIDTH-1:0] acc_ff;
   logic                        sat_ff;
   logic signed [ACC_WIDTH-1:0] acc_in;
   logic                        sat_in;
   logic signed [SUM_W-1:0]     acc_ext;
   logic signed [SUM_W-1:0]     act_ext;
   logic signed [SUM_W-1:0]     raw;
   logic                        active;

   assign acc_ext = SUM_W'(acc_ff);
   assign act_ext = SUM_W'(activation);

   always_comb begin
      raw    = acc_ext;
      active = 1'b1;
      case (code)
         twdp_pkg::CODE_PLUS:  raw = acc_ext + act_ext;
         twdp_pkg::CODE_MINUS: raw = acc_ext - act_ext;
         default:              active = 1'b0;
      endcase
   end

   // Clamp to the accumulator range and latch the flag on any clamp
   always_comb begin
      sum_next = acc_ff;
      sat_next = sat_ff;
      if (active) begin
         if (raw > SUM_W'(ACC_MAX)) begin
            sum_next = ACC_MAX;
            sat_next = 1'b1;
         end else if (raw < SUM_W'(ACC_MIN)) begin
            sum_next = ACC_MIN;
            sat_next = 1'b1;
         end else begin
            sum_next = ACC_WIDTH'(raw);
         end
      end
   end

   always_comb begin
      acc_in = acc_ff;
      sat_in = sat_ff;
      if (accept) begin
         acc_in = last ? '0 : sum_next;
         sat_in = last ? 1'b0 : sat_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         sat_ff <= 1'b0;
      end else begin
         acc_ff <= acc_in;
         sat_ff <= sat_in;
      end
   end

endmodule

### hw/rtl/twdp_drain.sv
`timescale 1ns / 1ps

module twdp_drain #(
   parameter int LANES     = 16,
   parameter int ACC_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  twdp_pkg::capture_type                 capture,
   input  logic signed [ACC_WIDTH-1:0]           lane_sum [LANES],
   input  logic                                  lane_sat [LANES],
   output logic                                  busy,
   input  logic                                  rsp_tready,
   output logic                                  rsp_tvalid,
   output logic [twdp_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   output logic                                  rsp_tuser,
   output logic                                  rsp_tlast
);

   localparam int PTR_W = (LANES > 1) ? $clog2(LANES) : 1;

   logic signed [ACC_WIDTH-1:0]        snap_sum_ff [LANES];
   logic                               snap_sat_ff [LANES];
   logic [twdp_pkg::COL_W-1:0]         snap_col_ff;
   logic [PTR_W-1:0]                   ptr_ff, ptr_in;
   logic                               busy_ff, busy_in;
   logic                               valid_ff, valid_in;
   logic [twdp_pkg::LANE_IDX_W-1:0]    lane_ff;
   logic [twdp_pkg::COL_W-1:0]         col_ff;
   logic [twdp_pkg::SUM_OUT_W-1:0]     sum_ff;
   logic                               sat_ff;
   logic                               last_ff;
   logic                               out_free;
   logic                               advance;
   logic                               last_lane;

   assign out_free  = !valid_ff || rsp_tready;
   assign advance   = busy_ff && out_free;
   assign last_lane = (ptr_ff == PTR_W'(LANES - 1));

   always_comb begin
      busy_in  = busy_ff;
      ptr_in   = ptr_ff;
      valid_in = valid_ff;
      if (advance) begin
         valid_in = 1'b1;
         ptr_in   = ptr_ff + 1'b1;
         if (last_lane) busy_in = 1'b0;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
      if (capture.take) begin
         busy_in = 1'b1;
         ptr_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         ptr_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         ptr_ff   <= ptr_in;
         valid_ff <= valid_in;
      end
   end

   // Snapshot of the finished column, then one lane per transfer
   always_ff @(posedge clock) begin
      if (capture.take) begin
         snap_sum_ff <= lane_sum;
         snap_sat_ff <= lane_sat;
         snap_col_ff <= capture.column;
      end
      if (advance) begin
         lane_ff <= twdp_pkg::LANE_IDX_W'(ptr_ff);
         col_ff  <= snap_col_ff;
         sum_ff  <= twdp_pkg::SUM_OUT_W'(snap_sum_ff[ptr_ff]);
         sat_ff  <= snap_sat_ff[ptr_ff];
         last_ff <= last_lane;
      end
   end

   assign busy       = busy_ff;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {4'b0, sum_ff, col_ff, lane_ff};
   assign rsp_tuser  = sat_ff;
   assign rsp_tlast  = last_ff;

endmodule

### hw/rtl/ternary_weight_dot_product_unit.sv
`timescale 1ns / 1ps

// Ternary-weight dot-product tile. Each req transfer carries one Q1.14
// activation and the two-bit weight codes of LANES output rows; every lane
// adds (+1), subtracts (-1) or ignores the activation in a saturating
// accumulator, all lanes in the same cycle. A transfer with req_tlast set
// closes the column: the final sums are snapshotted into the result drain,
// the accumulators clear, and the drain sends one rsp transfer per lane in
// lane order, tagged with the column index (which wraps at column_count)
// and a saturation flag. Input items are taken one per cycle; the only stall
// is a closing item that arrives while the previous column's results are
// still draining. The floor per column is the one-result-per-cycle output
// port, while rsp_tready holds, and the drain frees the snapshot only once
// its last lane has moved to the output register. The closing transfer
// registers the snapshot, and the drain then registers the first result.
module ternary_weight_dot_product_unit #(
   parameter int LANES     = 16,
   parameter int ACT_WIDTH = 16,
   parameter int ACC_WIDTH = 32,
   localparam int REQ_TDATA_W = ((ACT_WIDTH + 2 * LANES + 7) / 8) * 8
) (
   input  logic                                clock,
   input  logic                                reset,
   // activation [ACT_WIDTH-1:0], weight_trits [ACT_WIDTH +: 2*LANES], zero pad
   input  logic [REQ_TDATA_W-1:0]              req_tdata,
   input  logic                                req_tlast,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // lane_index [3:0], column_index [11:4], dot_sum [43:12], zero pad
   output logic [twdp_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // saturated [0]
   output logic                                rsp_tuser,
   output logic                                rsp_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [twdp_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [twdp_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [twdp_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   logic [twdp_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic [twdp_pkg::COL_W-1:0]     column_ff, column_in;
   logic [twdp_pkg::COUNT_W-1:0]   eff_count;
   logic [twdp_pkg::COUNT_W-1:0]   column_step;
   logic                           csr_write;
   logic                           accept;
   logic                           close;
   logic                           drain_busy;
   twdp_pkg::capture_type          capture;
   logic signed [ACT_WIDTH-1:0]    activation;
   logic signed [ACC_WIDTH-1:0]    lane_sum [LANES];
   logic                           lane_sat [LANES];

   // Configuration: one register, column_count, at byte address 0
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == twdp_pkg::REG_COLUMN_COUNT);
   assign csr_prdata = (csr_paddr[2] == twdp_pkg::REG_COLUMN_COUNT)
                       ? twdp_pkg::CSR_DATA_W'(count_ff) : '0;

   // Hold a closing item back while the drain still owns the snapshot
   assign req_tready = !req_tlast || !drain_busy;
   assign accept     = req_tvalid && req_tready;
   assign close      = accept && req_tlast;
   assign activation = req_tdata[ACT_WIDTH-1:0];

   // Clamp the count to 1..256 before the wrap compare
   always_comb begin
      eff_count = count_ff;
      if (count_ff == '0) eff_count = twdp_pkg::COUNT_W'(1);
      else if (count_ff > twdp_pkg::COUNT_W'(256)) eff_count = twdp_pkg::COUNT_W'(256);
   end

   assign column_step = twdp_pkg::COUNT_W'(column_ff) + 1'b1;

   always_comb begin
      count_in  = count_ff;
      column_in = column_ff;
      if (csr_write) count_in = csr_pwdata[twdp_pkg::COUNT_W-1:0];
      if (close) begin
         column_in = (column_step >= eff_count) ? '0
                                                : column_step[twdp_pkg::COL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= twdp_pkg::COUNT_W'(1);
         column_ff <= '0;
      end else begin
         count_ff  <= count_in;
         column_ff <= column_in;
      end
   end

   assign capture.take   = close;
   assign capture.column = column_ff;

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      twdp_lane #(
         .ACT_WIDTH (ACT_WIDTH),
         .ACC_WIDTH (ACC_WIDTH)
      ) u_lane (
         .clock      (clock),
         .reset      (reset),
         .accept     (accept),
         .last       (req_tlast),
         .activation (activation),
         .code       (req_tdata[ACT_WIDTH + 2 * i +: 2]),
         .sum_next   (lane_sum[i]),
         .sat_next   (lane_sat[i])
      );
   end

   twdp_drain #(
      .LANES     (LANES),
      .ACC_WIDTH (ACC_WIDTH)
   ) u_drain (
      .clock      (clock),
      .reset      (reset),
      .capture    (capture),
      .lane_sum   (lane_sum),
      .lane_sat   (lane_sat),
      .busy       (drain_busy),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### hw/rtl/twdp_checker.sv
`timescale 1ns / 1ps

module twdp_checker #(
   parameter int LANES     = 16,
   parameter int ACT_WIDTH = 16,
   parameter int ACC_WIDTH = 32,
   localparam int REQ_TDATA_W = ((ACT_WIDTH + 2 * LANES + 7) / 8) * 8
) (
   input logic                                clock,
   input logic                                reset,
   input logic [REQ_TDATA_W-1:0]              req_tdata,
   input logic                                req_tlast,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [twdp_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input logic                                rsp_tuser,
   input logic                                rsp_tlast,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready
);

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // Only the top lane closes a column
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[twdp_pkg::LANE_IDX_W-1:0]
                                    == twdp_pkg::LANE_IDX_W'(LANES - 1))))
      else $error("last_result on wrong lane");

   // Inner items never stall
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> req_tlast)
      else $error("non-closing item stalled");

   // No result straight out of reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind ternary_weight_dot_product_unit twdp_checker #(
   .LANES     (LANES),
   .ACT_WIDTH (ACT_WIDTH),
   .ACC_WIDTH (ACC_WIDTH)
) u_twdp_checker (.*);

### verif/tb_ternary_weight_dot_product_unit.sv
`timescale 1ns / 1ps

module tb_ternary_weight_dot_product_unit;

   localparam int LANES       = 16;
   localparam int ACT_W       = 16;
   localparam int REQ_W       = ((ACT_W + 2 * LANES + 7) / 8) * 8;
   localparam int MAX_COLUMNS = 256;

   // Run shape
   localparam int RESET_CYCLES    = 6;
   localparam int DRAIN_CYCLES    = 8;
   localparam int QUIET_LIMIT     = 2000;  // cycles with no transfer on either channel
   localparam int RANDOM_PHASES   = 6;
   localparam int ITEMS_PER_PHASE = 20;
   localparam int SOAK_PHASE      = RANDOM_PHASES + 1;
   localparam int SOAK_ITEMS      = 16;    // one long column at the most negative activation
   localparam int SOAK_TAIL       = 3;

   // Register map: the register select sits at paddr[2]
   localparam logic [twdp_pkg::CSR_ADDR_W-1:0] ADDR_COLUMN_COUNT =
      {twdp_pkg::REG_COLUMN_COUNT, 2'b00};
   localparam logic [twdp_pkg::CSR_ADDR_W-1:0] ADDR_UNMAPPED     =
      {~twdp_pkg::REG_COLUMN_COUNT, 2'b00};

   // The two weight codes that leave a lane untouched
   localparam logic [1:0] CODE_SKIP_LO = 2'd0;
   localparam logic [1:0] CODE_SKIP_HI = 2'd3;

   localparam logic [2*LANES-1:0] TRITS_PLUS    = {LANES{twdp_pkg::CODE_PLUS}};
   localparam logic [2*LANES-1:0] TRITS_MINUS   = {LANES{twdp_pkg::CODE_MINUS}};
   localparam logic [2*LANES-1:0] TRITS_SKIP_HI = {LANES{CODE_SKIP_HI}};
   localparam logic [2*LANES-1:0] TRITS_SKIP_LO = {LANES{CODE_SKIP_LO}};
   // lane 4k: skip (0), 4k+1: plus, 4k+2: minus, 4k+3: skip (3)
   localparam logic [2*LANES-1:0] TRITS_MIXED   =
      {(LANES / 4){CODE_SKIP_HI, twdp_pkg::CODE_MINUS, twdp_pkg::CODE_PLUS, CODE_SKIP_LO}};
   // lanes 0-3 plus, 4-7 minus, 8-11 both skip codes, 12-15 mixed
   localparam logic [2*LANES-1:0] TRITS_SOAK    =
      {CODE_SKIP_HI, twdp_pkg::CODE_MINUS, twdp_pkg::CODE_PLUS, CODE_SKIP_LO,
       {2{CODE_SKIP_HI, CODE_SKIP_LO}}, {4{twdp_pkg::CODE_MINUS}},
       {4{twdp_pkg::CODE_PLUS}}};

   localparam logic signed [ACT_W-1:0] ACT_MAX = {1'b0, {(ACT_W-1){1'b1}}};
   localparam logic signed [ACT_W-1:0] ACT_MIN = {1'b1, {(ACT_W-1){1'b0}}};

   // Clamp bounds, one guard bit wider than the accumulator
   localparam logic signed [twdp_pkg::SUM_OUT_W:0] ACC_MAX =
      {2'b00, {(twdp_pkg::SUM_OUT_W-1){1'b1}}};
   localparam logic signed [twdp_pkg::SUM_OUT_W:0] ACC_MIN =
      {2'b11, {(twdp_pkg::SUM_OUT_W-1){1'b0}}};

   typedef struct packed {
      logic signed [ACT_W-1:0] activation;
      logic [2*LANES-1:0]      weight_trits;
      logic                    last_element;
   } tile_item_type;

   typedef struct packed {
      logic [twdp_pkg::LANE_IDX_W-1:0]       lane;
      logic [twdp_pkg::COL_W-1:0]            column;
      logic signed [twdp_pkg::SUM_OUT_W-1:0] dot_sum;
      logic                                  clamped;
      logic                                  final_lane;
   } lane_sum_type;

   // Ports of the block; the inputs it is driven with are known from time zero
   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic [REQ_W-1:0]                    req_tdata = '0;
   logic                                req_tlast = 1'b0;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [twdp_pkg::RSP_TDATA_W-1:0]    rsp_tdata;
   logic                                rsp_tuser;
   logic                                rsp_tlast;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic                                csr_psel = 1'b0;
   logic                                csr_penable = 1'b0;
   logic                                csr_pwrite = 1'b0;
   logic [twdp_pkg::CSR_ADDR_W-1:0]     csr_paddr = '0;
   logic [twdp_pkg::CSR_DATA_W-1:0]     csr_pwdata = '0;
   logic [twdp_pkg::CSR_DATA_W-1:0]     csr_prdata;
   logic                                csr_pready;

   // Items waiting to be offered, and lane sums waiting to come back
   tile_item_type tile_items[$];
   lane_sum_type  expected_sums[$];

   // Shadow of the tile: accumulators, clamp flags, column counter, register
   logic signed [twdp_pkg::SUM_OUT_W-1:0] lane_sums[LANES] = '{default: '0};
   logic                                  lane_clamped[LANES] = '{default: 1'b0};
   logic [twdp_pkg::COL_W-1:0]            column_index = '0;
   logic [twdp_pkg::COUNT_W-1:0]          column_limit = twdp_pkg::COUNT_W'(1);

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int mismatch_count = 0;
   int quiet_cycles = 0;

   ternary_weight_dot_product_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Apply one input item to every lane; on the closing item, emit the
   // 16 lane sums in lane order, clear the lanes and step the column counter.
   function automatic void accumulate_lanes(input logic signed [ACT_W-1:0] act,
                                            input logic [2*LANES-1:0] trits,
                                            input logic closing);
      logic signed [twdp_pkg::SUM_OUT_W:0] s;
      logic [1:0]                          code;
      int unsigned                         span;
      lane_sum_type                        r;
      int                                  lane;
      for (lane = 0; lane < LANES; lane++) begin
         code = trits[2*lane +: 2];
         if (code == twdp_pkg::CODE_PLUS || code == twdp_pkg::CODE_MINUS) begin
            s = (code == twdp_pkg::CODE_PLUS) ? lane_sums[lane] + act
                                              : lane_sums[lane] - act;
            // clamp at either bound and remember it until the column closes
            if (s > ACC_MAX) begin
               s = ACC_MAX;
               lane_clamped[lane] = 1'b1;
            end else if (s < ACC_MIN) begin
               s = ACC_MIN;
               lane_clamped[lane] = 1'b1;
            end
            lane_sums[lane] = s[twdp_pkg::SUM_OUT_W-1:0];
         end
      end
      if (closing) begin
         // a count of zero acts as one, anything above the maximum as the maximum
         span = (column_limit == 0) ? 1 :
                (column_limit > MAX_COLUMNS) ? MAX_COLUMNS : column_limit;
         for (lane = 0; lane < LANES; lane++) begin
            r.lane       = twdp_pkg::LANE_IDX_W'(lane);
            r.column     = column_index;
            r.dot_sum    = lane_sums[lane];
            r.clamped    = lane_clamped[lane];
            r.final_lane = (lane == LANES - 1);
            expected_sums.push_back(r);
            lane_sums[lane]    = '0;
            lane_clamped[lane] = 1'b0;
         end
         // a counter already at or past a freshly lowered count wraps here
         column_index = (column_index + 1 >= span) ? '0 : column_index + 1'b1;
      end
   endfunction

   function automatic void queue_item(input logic signed [ACT_W-1:0] act,
                                      input logic [2*LANES-1:0] trits,
                                      input logic closing);
      tile_item_type item;
      item.activation   = act;
      item.weight_trits = trits;
      item.last_element = closing;
      tile_items.push_back(item);
   endfunction

   // Lean on the extremes now and then; otherwise any bit pattern
   function automatic logic signed [ACT_W-1:0] random_activation();
      int unsigned pick;
      pick = $urandom_range(7);
      if (pick == 0) return ACT_MIN;
      if (pick == 1) return ACT_MAX;
      return ACT_W'($urandom);
   endfunction

   function automatic logic [2*LANES-1:0] random_trits();
      int unsigned pick;
      pick = $urandom_range(9);
      if (pick == 0) return TRITS_PLUS;
      if (pick == 1) return TRITS_MINUS;
      if (pick == 2) return TRITS_SKIP_HI;
      return (2*LANES)'($urandom);
   endfunction

   // Setup cycle, then access cycle; the register takes the data at the edge
   // where the access phase meets pready.
   task automatic write_register(input logic [twdp_pkg::CSR_ADDR_W-1:0] addr,
                                 input logic [twdp_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      // writes with the other register select at paddr[2] are dropped by the block
      if (addr == ADDR_COLUMN_COUNT) column_limit = value[twdp_pkg::COUNT_W-1:0];
   endtask

   // Hold until every item is taken and every lane sum is back, then let
   // the pipeline settle.
   task automatic wait_for_idle();
      while (tile_items.size() != 0 || req_tvalid || expected_sums.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Input driver: offer the next item once the current one has transferred,
   // idling at random.
   always @(posedge clock) begin
      tile_item_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (tile_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            item = tile_items.pop_front();
            req_tdata  <= {item.weight_trits, item.activation};
            req_tlast  <= item.last_element;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result side back-pressure
   always @(posedge clock) begin
      rsp_tready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   // Monitor: feed each input transfer to the shadow tile and check each
   // result transfer against the oldest expected lane sum.
   always @(posedge clock) begin
      lane_sum_type got;
      lane_sum_type want;
      if (!reset) begin
         if (req_tvalid && req_tready)
            accumulate_lanes(req_tdata[ACT_W-1:0], req_tdata[ACT_W +: 2*LANES], req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            got.lane       = rsp_tdata[twdp_pkg::LANE_IDX_W-1:0];
            got.column     = rsp_tdata[twdp_pkg::LANE_IDX_W +: twdp_pkg::COL_W];
            got.dot_sum    = rsp_tdata[twdp_pkg::LANE_IDX_W + twdp_pkg::COL_W
                                       +: twdp_pkg::SUM_OUT_W];
            got.clamped    = rsp_tuser;
            got.final_lane = rsp_tlast;
            if (expected_sums.size() == 0) begin
               $error("result transfer with no lane sum expected: lane_index %0d",
                      got.lane);
               mismatch_count++;
            end else begin
               want = expected_sums.pop_front();
               if (got.lane !== want.lane) begin
                  $error("lane_index: expected %0d, got %0d", want.lane, got.lane);
                  mismatch_count++;
               end
               if (got.column !== want.column) begin
                  $error("column_index: expected %0d, got %0d", want.column, got.column);
                  mismatch_count++;
               end
               if (got.dot_sum !== want.dot_sum) begin
                  $error("dot_sum: expected %0d, got %0d", want.dot_sum, got.dot_sum);
                  mismatch_count++;
               end
               if (got.clamped !== want.clamped) begin
                  $error("saturated: expected %0b, got %0b", want.clamped, got.clamped);
                  mismatch_count++;
               end
               if (got.final_lane !== want.final_lane) begin
                  $error("last_result: expected %0b, got %0b",
                         want.final_lane, got.final_lane);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // Watchdog: drop the run if neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Stimulus: directed columns at the reset count, six random phases with a
   // fresh column count each, then one long column that runs lanes both ways.
   initial begin
      int phase;
      int filled;
      int span;
      int k;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (phase = 0; phase <= SOAK_PHASE; phase++) begin
         wait_for_idle();

         // Column count changes only while the tile is idle
         case (phase)
            1: write_register(ADDR_COLUMN_COUNT, 32'd0);
            2: write_register(ADDR_COLUMN_COUNT, 32'd256);
            3: begin
               write_register(ADDR_UNMAPPED, 32'd7);
               // lowered below the running counter: the next close wraps it
               write_register(ADDR_COLUMN_COUNT, 32'd3);
            end
            4: write_register(ADDR_COLUMN_COUNT, 32'd511);
            5: write_register(ADDR_COLUMN_COUNT, 32'hFFFF_FE05);
            6: write_register(ADDR_COLUMN_COUNT, 32'd1);
            SOAK_PHASE: write_register(ADDR_COLUMN_COUNT, 32'd2);
            default: ;
         endcase

         // Sender idles lightly against a slow receiver, then the reverse,
         // then both run flat out.
         send_idle_pct <= (phase < 3) ? 28 : (phase < 5) ? 86 : 0;
         recv_idle_pct <= (phase < 3) ? 86 : (phase < 5) ? 28 : 0;

         if (phase == 0) begin
            // Extremes, each code, open columns and one-item columns
            queue_item(ACT_MAX, TRITS_PLUS, 1'b0);
            queue_item(ACT_MIN, TRITS_MINUS, 1'b0);
            queue_item(-16'sd1, TRITS_SKIP_HI, 1'b0);
            queue_item(16'sd1, TRITS_MIXED, 1'b1);
            queue_item(16'sd0, TRITS_PLUS, 1'b1);
            queue_item(ACT_MIN, TRITS_PLUS, 1'b1);
            // negate the most negative activation
            queue_item(ACT_MIN, TRITS_MINUS, 1'b1);
            queue_item(ACT_MAX, TRITS_MINUS, 1'b1);
            queue_item(16'sd12345, TRITS_MIXED, 1'b0);
            queue_item(-16'sd23456, TRITS_SKIP_LO, 1'b0);
            queue_item(ACT_MAX, TRITS_MIXED, 1'b1);
            for (k = 0; k < 6; k++)
               queue_item(random_activation(), random_trits(), 1'b1);
         end else if (phase <= RANDOM_PHASES) begin
            // Whole columns: mostly shorter than the drain, some longer
            filled = 0;
            while (filled < ITEMS_PER_PHASE) begin
               span = ($urandom_range(4) == 0) ? $urandom_range(10, 24)
                                               : $urandom_range(1, 6);
               for (k = 1; k <= span; k++)
                  queue_item(random_activation(), random_trits(), k == span);
               filled += span;
            end
         end else begin
            // Plus lanes run downwards and minus lanes upwards within one
            // column; the tail then moves the sums again and closes it.
            for (k = 0; k < SOAK_ITEMS; k++)
               queue_item(ACT_MIN, TRITS_SOAK, 1'b0);
            for (k = 1; k <= SOAK_TAIL; k++)
               queue_item(random_activation(), random_trits(), k == SOAK_TAIL);
         end
      end

      wait_for_idle();
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
